[hdl/tshe_pkg.sv]
// Shared types and constants for the tape sensor hysteresis event block.
package tshe_pkg;

  localparam int NUM_TAPE_CHANNELS = 6;
  localparam int SAMPLE_BITS_DEF   = 10;
  localparam int NUM_EVENTS        = NUM_TAPE_CHANNELS + 1;
  localparam int IDX_BITS          = $clog2(NUM_EVENTS);
  localparam int CFG_IDX_BITS      = 3;
  localparam int THR_MIN_BITS      = 10;

  // Channels allowed to change in edge-following mode (0, 1, 4, 5).
  localparam logic [15:0] EDGE_CHANNEL_MASK = 16'h0033;

  localparam int LOW_THR_RST   = 200;
  localparam int HIGH_THR_RST  = 450;
  localparam int TOWER_LOW_RST = 600;
  localparam int TOWER_HI_RST  = 900;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOW_THR   = 3'd0,
    REG_HIGH_THR  = 3'd1,
    REG_TOWER_LOW = 3'd2,
    REG_TOWER_HI  = 3'd3,
    REG_EDGE_MODE = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_TAPE_OFF  = 2'd0,
    EV_TAPE_ON   = 2'd1,
    EV_TOWER_OFF = 2'd2,
    EV_TOWER_ON  = 2'd3
  } event_kind_t;

  // Outcome of one sample set against the current state.
  typedef struct packed {
    logic [NUM_TAPE_CHANNELS-1:0] tape_next;
    logic [NUM_TAPE_CHANNELS-1:0] tape_chg;
    logic                         tower_next;
    logic                         tower_chg;
  } eval_res_t;

endpackage

[hdl/tshe_eval.sv]
// Hysteresis comparators for the tape channels and the tower pair.
module tshe_eval #(
  parameter int SAMPLE_BITS = tshe_pkg::SAMPLE_BITS_DEF,
  parameter int THR_BITS    = tshe_pkg::THR_MIN_BITS
) (
  input  logic [SAMPLE_BITS-1:0]                 tape_lvl [tshe_pkg::NUM_TAPE_CHANNELS],
  input  logic [SAMPLE_BITS-1:0]                 tower_l_lvl,
  input  logic [SAMPLE_BITS-1:0]                 tower_r_lvl,
  input  logic [THR_BITS-1:0]                    low_thr,
  input  logic [THR_BITS-1:0]                    high_thr,
  input  logic [THR_BITS-1:0]                    tower_low,
  input  logic [THR_BITS-1:0]                    tower_high,
  input  logic                                   edge_mode,
  input  logic [tshe_pkg::NUM_TAPE_CHANNELS-1:0] tape_old,
  input  logic                                   tower_old,
  output tshe_pkg::eval_res_t                    res
);

  logic [THR_BITS-1:0] tl_ext;
  logic [THR_BITS-1:0] tr_ext;
  logic                tower_nxt;

  always_comb begin
    logic [THR_BITS-1:0] lvl;
    logic                nxt;
    logic                allowed;
    res = '0;
    for (int i = 0; i < tshe_pkg::NUM_TAPE_CHANNELS; i++) begin
      lvl = THR_BITS'(tape_lvl[i]);
      nxt = tape_old[i];
      // on test first, so crossed thresholds favour on
      if (lvl > high_thr) begin
        nxt = 1'b1;
      end else if (lvl < low_thr) begin
        nxt = 1'b0;
      end
      allowed = !edge_mode || tshe_pkg::EDGE_CHANNEL_MASK[i];
      res.tape_chg[i]  = (nxt != tape_old[i]) && allowed;
      res.tape_next[i] = res.tape_chg[i] ? nxt : tape_old[i];
    end
    res.tower_next = tower_nxt;
    res.tower_chg  = (tower_nxt != tower_old);
  end

  assign tl_ext = THR_BITS'(tower_l_lvl);
  assign tr_ext = THR_BITS'(tower_r_lvl);

  // off test first for the pair
  always_comb begin
    tower_nxt = tower_old;
    if (tl_ext < tower_low || tr_ext < tower_low) begin
      tower_nxt = 1'b0;
    end else if (tl_ext > tower_high && tr_ext > tower_high) begin
      tower_nxt = 1'b1;
    end
  end

endmodule

[hdl/tshe_pick.sv]
// Picks the lowest pending event and clears it from the pending mask.
module tshe_pick (
  input  logic [tshe_pkg::NUM_EVENTS-1:0] mask,
  output logic [tshe_pkg::IDX_BITS-1:0]   idx,
  output logic [tshe_pkg::NUM_EVENTS-1:0] rest
);

  always_comb begin
    logic found;
    found = 1'b0;
    idx   = '0;
    rest  = mask;
    for (int i = 0; i < tshe_pkg::NUM_EVENTS; i++) begin
      if (mask[i] && !found) begin
        found   = 1'b1;
        idx     = tshe_pkg::IDX_BITS'(i);
        rest[i] = 1'b0;
      end
    end
  end

endmodule

[hdl/tape_sensor_hysteresis_events_core.sv]
// Top level of the tape sensor hysteresis event block.
//
//  channel | ports                         | beat
//  --------+-------------------------------+-----------------------------------
//  in      | in_valid/in_ready, 8 levels   | one sample set
//  out     | out_valid/out_ready, 5 fields | one on/off event with state bitmap
//  cfg     | cfg_valid/cfg_ready, idx+data | one register write
//
// A sample is registered, then compared against the state; its events go to
// a pending mask that drains one event per cycle into the output register.
// A sample with no events leaves the pending mask empty. An event passes the
// input register, the pending mask and the output register in that order.
// Reset clears state and loads the default levels. out_ready low stalls the
// drain; the input keeps taking one sample while the pending mask is busy.
module tape_sensor_hysteresis_events_core #(
  parameter int SAMPLE_BITS = tshe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [SAMPLE_BITS-1:0]                 in_front_right_level,
  input  logic [SAMPLE_BITS-1:0]                 in_front_left_level,
  input  logic [SAMPLE_BITS-1:0]                 in_rear_right_level,
  input  logic [SAMPLE_BITS-1:0]                 in_rear_left_level,
  input  logic [SAMPLE_BITS-1:0]                 in_side_right_level,
  input  logic [SAMPLE_BITS-1:0]                 in_side_left_level,
  input  logic [SAMPLE_BITS-1:0]                 in_tower_left_level,
  input  logic [SAMPLE_BITS-1:0]                 in_tower_right_level,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             out_event_kind,
  output logic [tshe_pkg::IDX_BITS-1:0]          out_sensor_index,
  output logic [tshe_pkg::NUM_TAPE_CHANNELS-1:0] out_tape_state_bits,
  output logic                                   out_tower_state,
  output logic                                   out_last_of_run,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tshe_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [SAMPLE_BITS-1:0]                 cfg_data
);

  localparam int NumCh   = tshe_pkg::NUM_TAPE_CHANNELS;
  localparam int NumEv   = tshe_pkg::NUM_EVENTS;
  localparam int ThrBits = (SAMPLE_BITS > tshe_pkg::THR_MIN_BITS) ?
                           SAMPLE_BITS : tshe_pkg::THR_MIN_BITS;

  // configuration
  logic [ThrBits-1:0] low_thr_r, high_thr_r, tower_low_r, tower_high_r;
  logic               edge_mode_r;

  // state
  logic [NumCh-1:0] tape_state_r;
  logic             tower_state_r;

  // input register
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_tape_r [NumCh];
  logic [SAMPLE_BITS-1:0] s1_tl_r, s1_tr_r;

  // pending events and the state snapshot they report
  logic [NumEv-1:0] pend_mask_r;
  logic [NumCh-1:0] pend_tape_r;
  logic             pend_tower_r;

  // output register
  logic                        out_valid_r;
  logic [1:0]                  out_kind_r;
  logic [tshe_pkg::IDX_BITS-1:0] out_idx_r;
  logic [NumCh-1:0]            out_tape_r;
  logic                        out_tower_r;
  logic                        out_last_r;

  tshe_pkg::eval_res_t           res;
  logic [tshe_pkg::IDX_BITS-1:0] pick_idx;
  logic [NumEv-1:0]              pick_rest;
  logic                          out_load_ok, pop, pend_free, s1_take, in_take;
  logic [1:0]                    pop_kind;

  assign cfg_ready   = 1'b1;
  assign out_load_ok = !out_valid_r || out_ready;
  assign pop         = (pend_mask_r != '0) && out_load_ok;
  assign pend_free   = (pend_mask_r == '0) || (pop && (pick_rest == '0));
  assign s1_take     = s1_valid_r && pend_free;
  assign in_ready    = !s1_valid_r || pend_free;
  assign in_take     = in_valid && in_ready;

  tshe_eval #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .THR_BITS    (ThrBits)
  ) u_eval (
    .tape_lvl    (s1_tape_r),
    .tower_l_lvl (s1_tl_r),
    .tower_r_lvl (s1_tr_r),
    .low_thr     (low_thr_r),
    .high_thr    (high_thr_r),
    .tower_low   (tower_low_r),
    .tower_high  (tower_high_r),
    .edge_mode   (edge_mode_r),
    .tape_old    (tape_state_r),
    .tower_old   (tower_state_r),
    .res         (res)
  );

  tshe_pick u_pick (
    .mask (pend_mask_r),
    .idx  (pick_idx),
    .rest (pick_rest)
  );

  always_comb begin
    if (pick_idx == tshe_pkg::IDX_BITS'(NumCh)) begin
      pop_kind = pend_tower_r ? tshe_pkg::EV_TOWER_ON : tshe_pkg::EV_TOWER_OFF;
    end else begin
      pop_kind = pend_tape_r[pick_idx] ? tshe_pkg::EV_TAPE_ON : tshe_pkg::EV_TAPE_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r     <= ThrBits'(tshe_pkg::LOW_THR_RST);
      high_thr_r    <= ThrBits'(tshe_pkg::HIGH_THR_RST);
      tower_low_r   <= ThrBits'(tshe_pkg::TOWER_LOW_RST);
      tower_high_r  <= ThrBits'(tshe_pkg::TOWER_HI_RST);
      edge_mode_r   <= 1'b0;
      tape_state_r  <= '0;
      tower_state_r <= 1'b0;
      s1_valid_r    <= 1'b0;
      pend_mask_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tshe_pkg::REG_LOW_THR:   low_thr_r    <= ThrBits'(cfg_data);
          tshe_pkg::REG_HIGH_THR:  high_thr_r   <= ThrBits'(cfg_data);
          tshe_pkg::REG_TOWER_LOW: tower_low_r  <= ThrBits'(cfg_data);
          tshe_pkg::REG_TOWER_HI:  tower_high_r <= ThrBits'(cfg_data);
          tshe_pkg::REG_EDGE_MODE: edge_mode_r  <= cfg_data[0];
          default: ;
        endcase
      end

      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_take) begin
        tape_state_r  <= res.tape_next;
        tower_state_r <= res.tower_next;
        pend_mask_r   <= {res.tower_chg, res.tape_chg};
      end else if (pop) begin
        pend_mask_r <= pick_rest;
      end

      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tape_r[0] <= in_front_right_level;
      s1_tape_r[1] <= in_front_left_level;
      s1_tape_r[2] <= in_rear_right_level;
      s1_tape_r[3] <= in_rear_left_level;
      s1_tape_r[4] <= in_side_right_level;
      s1_tape_r[5] <= in_side_left_level;
      s1_tl_r      <= in_tower_left_level;
      s1_tr_r      <= in_tower_right_level;
    end
    if (s1_take) begin
      pend_tape_r  <= res.tape_next;
      pend_tower_r <= res.tower_next;
    end
    if (pop) begin
      out_kind_r  <= pop_kind;
      out_idx_r   <= pick_idx;
      out_tape_r  <= pend_tape_r;
      out_tower_r <= pend_tower_r;
      out_last_r  <= (pick_rest == '0);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = out_kind_r;
  assign out_sensor_index    = out_idx_r;
  assign out_tape_state_bits = out_tape_r;
  assign out_tower_state     = out_tower_r;
  assign out_last_of_run     = out_last_r;

`ifndef NO_ASSERTIONS
  // the last pending event of a sample is flagged as last on the output
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pick_rest == '0) |=> out_last_of_run)
    else $error("last event of a sample not flagged");

  // the tower pair only ever reports tower kinds
  a_tower_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sensor_index == tshe_pkg::IDX_BITS'(NumCh)) |-> out_event_kind[1])
    else $error("tower event with tape kind");

  // snapshot taken with a sample matches the state it leaves behind
  a_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take |=> (pend_tape_r == tape_state_r && pend_tower_r == tower_state_r))
    else $error("pending snapshot differs from state");

  // a tape event reports the channel's state in its own bitmap
  a_tape_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pick_idx != tshe_pkg::IDX_BITS'(NumCh)) |=>
      (out_event_kind[0] == out_tape_state_bits[out_sensor_index]))
    else $error("tape event kind disagrees with bitmap");
`endif

endmodule
